// ----- rtl/lpft_pkg.sv -----
`timescale 1ns / 1ps

package lpft_pkg;

   // Default frame count of the translator
   localparam int DEFAULT_FRAMES = 8;

   // Access and address fields
   localparam int ADDR_W      = 24;
   localparam int PAGE_W      = 15;
   localparam int OFFS_W      = 9;
   localparam int FRAME_OUT_W = 3;

   // Backing store positions and counts
   localparam int POS_W   = 32;
   localparam int BASE_W  = 31;
   localparam int PAGES_W = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_WRITEBACK_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_OFFSET      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_PAGES    = 2'd2;

   // Access kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Store page count saturates here
   localparam logic [PAGES_W-1:0] PAGES_MAX = 16'hFFFF;

endpackage

// ----- rtl/lpft_ram.sv -----
`timescale 1ns / 1ps

module lpft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/lru_page_frame_translator.sv -----
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// req      req_valid / req_stall   req_kind, req_address
// rsp      rsp_valid / rsp_stall   hit, frame, page_offset, fill/writeback info, grow
// csr      csr_valid / csr_ready   csr_index, csr_data
//
// The tag search and the rank update each walk the filled frames (at most FRAMES)
// one entry a cycle through the registered read port of the table RAMs.
// req_stall is high from accept until the result is loaded into the output register.
// Synchronous active-high reset clears the sequencer, the filled-frame count, the
// configuration registers and the output valid flag; no table clearing.
// A result held by rsp_stall keeps the block from finishing the next access only.
module lru_page_frame_translator #(
   parameter int FRAMES = lpft_pkg::DEFAULT_FRAMES
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [lpft_pkg::ADDR_W-1:0]          req_address,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic [lpft_pkg::FRAME_OUT_W-1:0]     rsp_frame,
   output logic [lpft_pkg::OFFS_W-1:0]          rsp_page_offset,
   output logic                                 rsp_fill_needed,
   output logic [lpft_pkg::POS_W-1:0]           rsp_fill_position,
   output logic                                 rsp_writeback_needed,
   output logic [lpft_pkg::POS_W-1:0]           rsp_writeback_position,
   output logic                                 rsp_grow_store,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lpft_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lpft_pkg::CSR_DATA_W-1:0]      csr_data
);

   import lpft_pkg::*;

   localparam int FW        = $clog2(FRAMES);
   localparam int UW        = $clog2(FRAMES + 1);
   localparam int RW        = FW;
   localparam int RAM_DEPTH = 1 << FW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_AGE,
      ST_COMMIT,
      ST_DONE
   } state_type;

   state_type           state_ff;

   // Configuration
   logic                wb_enable_ff;
   logic [BASE_W-1:0]   base_ff;
   logic [PAGES_W-1:0]  store_pages_ff;

   // Table bookkeeping
   logic [UW-1:0]       used_ff;
   logic [UW-1:0]       cnt_ff;
   logic                chk_ff;
   logic [FW-1:0]       idx_ff;

   // Current access
   logic [PAGE_W-1:0]   page_ff;
   logic [OFFS_W-1:0]   offs_ff;
   logic                grow_ff;
   logic [POS_W-1:0]    fill_pos_ff;
   logic [POS_W-1:0]    wb_pos_ff;
   logic                wb_ff;

   // Search results
   logic                found_ff;
   logic [FW-1:0]       hit_idx_ff;
   logic [RW-1:0]       hit_rank_ff;
   logic [FW-1:0]       best_idx_ff;
   logic [RW-1:0]       best_rank_ff;
   logic [PAGE_W-1:0]   best_tag_ff;

   // Update plan
   logic [FW-1:0]       frame_ff;
   logic [RW-1:0]       limit_ff;
   logic                age_all_ff;
   logic                fill_free_ff;

   // Output register
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [FW-1:0]       rsp_frame_ff;
   logic [OFFS_W-1:0]   rsp_offs_ff;
   logic [POS_W-1:0]    rsp_fill_pos_ff;
   logic                rsp_wb_ff;
   logic [POS_W-1:0]    rsp_wb_pos_ff;
   logic                rsp_grow_ff;

   // Table RAM ports
   logic                tag_we;
   logic [PAGE_W-1:0]   tag_rdata;
   logic                rank_we;
   logic [FW-1:0]       rank_waddr;
   logic [RW-1:0]       rank_wdata;
   logic [RW-1:0]       rank_rdata;

   // Shared position adder
   logic [PAGE_W-1:0]   add_page;
   logic [POS_W-1:0]    add_sum;

   logic                req_xfer;
   logic [PAGE_W-1:0]   req_page;
   logic [FW+2:0]       frame_wide;

   assign req_page  = req_address[ADDR_W-1:OFFS_W];
   assign req_xfer  = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // base + page * 512, for the requested page at accept, for the victim at decide
   assign add_page = (state_ff == ST_IDLE) ? req_page : best_tag_ff;
   assign add_sum  = {1'b0, base_ff} + {{(POS_W - PAGE_W - OFFS_W){1'b0}}, add_page,
                                        {OFFS_W{1'b0}}};

   // Table writes: rank aging read-modify-write, then the final tag/rank store
   always_comb begin
      tag_we     = (state_ff == ST_COMMIT);
      rank_we    = 1'b0;
      rank_waddr = frame_ff;
      rank_wdata = '0;
      if (state_ff == ST_AGE && chk_ff && (age_all_ff || rank_rdata < limit_ff)) begin
         rank_we    = 1'b1;
         rank_waddr = idx_ff;
         rank_wdata = rank_rdata + RW'(1);
      end else if (state_ff == ST_COMMIT) begin
         rank_we    = 1'b1;
      end
   end

   lpft_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (RAM_DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (frame_ff),
      .wr_data (page_ff),
      .rd_addr (cnt_ff[FW-1:0]),
      .rd_data (tag_rdata)
   );

   lpft_ram #(
      .WIDTH (RW),
      .DEPTH (RAM_DEPTH)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_waddr),
      .wr_data (rank_wdata),
      .rd_addr (cnt_ff[FW-1:0]),
      .rd_data (rank_rdata)
   );

   // Sequencer, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         wb_enable_ff     <= 1'b0;
         base_ff          <= '0;
         store_pages_ff   <= '0;
         used_ff          <= '0;
         cnt_ff           <= '0;
         chk_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // A new result in the done state replaces the one leaving
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         // Register writes; unknown indexes are dropped
         if (csr_valid) begin
            case (csr_index)
               CSR_WRITEBACK_ENABLE: wb_enable_ff <= csr_data[0];
               CSR_BASE_OFFSET:      base_ff      <= csr_data[BASE_W-1:0];
               CSR_INITIAL_PAGES: begin
                  store_pages_ff   <= csr_data[PAGES_W-1:0];
               end
               default: ;
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  page_ff     <= req_page;
                  offs_ff     <= req_address[OFFS_W-1:0];
                  fill_pos_ff <= add_sum;
                  grow_ff     <= 1'b0;
                  // A write at or past the store end grows it by one page, saturating at PAGES_MAX
                  if (req_kind == KIND_WRITE
                      && {{(PAGES_W - PAGE_W){1'b0}}, req_page} >= store_pages_ff) begin
                     grow_ff <= 1'b1;
                     if (store_pages_ff != PAGES_MAX) begin
                        store_pages_ff <= store_pages_ff + PAGES_W'(1);
                     end
                  end
                  found_ff <= 1'b0;
                  cnt_ff   <= '0;
                  chk_ff   <= 1'b0;
                  state_ff <= ST_SEARCH;
               end
            end

            ST_SEARCH: begin
               // Compare the entry read last cycle
               if (chk_ff) begin
                  if (!found_ff && tag_rdata == page_ff) begin
                     found_ff    <= 1'b1;
                     hit_idx_ff  <= idx_ff;
                     hit_rank_ff <= rank_rdata;
                  end
                  if (idx_ff == '0 || rank_rdata > best_rank_ff) begin
                     best_idx_ff  <= idx_ff;
                     best_rank_ff <= rank_rdata;
                     best_tag_ff  <= tag_rdata;
                  end
               end
               // Issue the next read
               if (cnt_ff < used_ff) begin
                  idx_ff <= cnt_ff[FW-1:0];
                  chk_ff <= 1'b1;
                  cnt_ff <= cnt_ff + UW'(1);
               end else begin
                  chk_ff <= 1'b0;
                  if (!chk_ff) begin
                     state_ff <= ST_DECIDE;
                  end
               end
            end

            ST_DECIDE: begin
               wb_ff        <= 1'b0;
               wb_pos_ff    <= '0;
               age_all_ff   <= 1'b0;
               fill_free_ff <= 1'b0;
               if (found_ff) begin
                  frame_ff <= hit_idx_ff;
                  limit_ff <= hit_rank_ff;
               end else if (used_ff < UW'(FRAMES)) begin
                  frame_ff     <= used_ff[FW-1:0];
                  limit_ff     <= '0;
                  age_all_ff   <= 1'b1;
                  fill_free_ff <= 1'b1;
               end else begin
                  // Evict the least recent frame
                  frame_ff <= best_idx_ff;
                  limit_ff <= best_rank_ff;
                  if (wb_enable_ff) begin
                     wb_ff     <= 1'b1;
                     wb_pos_ff <= add_sum;
                  end
               end
               cnt_ff   <= '0;
               chk_ff   <= 1'b0;
               state_ff <= ST_AGE;
            end

            ST_AGE: begin
               // Read ranks one per cycle; each is written back in the cycle after its read
               if (cnt_ff < used_ff) begin
                  idx_ff <= cnt_ff[FW-1:0];
                  chk_ff <= 1'b1;
                  cnt_ff <= cnt_ff + UW'(1);
               end else begin
                  chk_ff <= 1'b0;
                  if (!chk_ff) begin
                     state_ff <= ST_COMMIT;
                  end
               end
            end

            ST_COMMIT: begin
               // Tag and most-recent rank are written by the RAM ports this cycle
               if (fill_free_ff) begin
                  used_ff <= used_ff + UW'(1);
               end
               state_ff <= ST_DONE;
            end

            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_hit_ff      <= found_ff;
                  rsp_frame_ff    <= frame_ff;
                  rsp_offs_ff     <= offs_ff;
                  rsp_fill_pos_ff <= fill_pos_ff;
                  rsp_wb_ff       <= wb_ff;
                  rsp_wb_pos_ff   <= wb_pos_ff;
                  rsp_grow_ff     <= grow_ff;
                  state_ff        <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Frame index reported in three bits; wider indexes wrap
   assign frame_wide = {3'b000, rsp_frame_ff};

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_hit                = rsp_hit_ff;
   assign rsp_frame              = frame_wide[FRAME_OUT_W-1:0];
   assign rsp_page_offset        = rsp_offs_ff;
   assign rsp_fill_needed        = !rsp_hit_ff;
   assign rsp_fill_position      = rsp_fill_pos_ff;
   assign rsp_writeback_needed   = rsp_wb_ff;
   assign rsp_writeback_position = rsp_wb_pos_ff;
   assign rsp_grow_store         = rsp_grow_ff;

endmodule
